// ===== rtl/core/led_index_to_xy_mapper_assert.svh =====
// assertion macros for the led index to xy mapper
`ifndef LED_INDEX_TO_XY_MAPPER_ASSERT_SVH
`define LED_INDEX_TO_XY_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS
`define LXY_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LXY_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LXY_ASSERT(label, clk, rst, prop, msg)
`define LXY_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/lxy_pkg.sv =====
// shared types and constants for the led index to xy mapper
`default_nettype none

package lxy_pkg;

   localparam int OPENING_COUNT   = 3;
   localparam int GEOMETRY_REGS   = 3;
   localparam int MAPPED_OPENINGS =
      (OPENING_COUNT < GEOMETRY_REGS) ? OPENING_COUNT : GEOMETRY_REGS;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int GEOMETRY_WIDTH  = 56;

   localparam logic [15:0] COORD_NONE = 16'hFFFF;

   typedef struct packed {
      logic [15:0] y_offset;
      logic [15:0] x_offset;
      logic [7:0]  right_count;
      logic [7:0]  top_count;
      logic [7:0]  left_count;
   } geometry_type;

   typedef geometry_type [GEOMETRY_REGS-1:0] geometry_array_type;

   typedef struct packed {
      logic [15:0] coord_x;
      logic [15:0] coord_y;
      logic        in_range;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/lxy_cfg_regs.sv =====
// opening geometry configuration registers
`default_nettype none

module lxy_cfg_regs
   import lxy_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [GEOMETRY_WIDTH-1:0]  csr_data,
   output      geometry_array_type         geometry
);

   geometry_array_type geometry_ff;
   geometry_array_type geometry_in;

   always_comb begin
      geometry_in = geometry_ff;
      for (int k = 0; k < GEOMETRY_REGS; k++) begin
         if (csr_valid && (32'(csr_index) == k)) begin
            geometry_in[k] = geometry_type'(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geometry_ff <= '0;
      end else begin
         geometry_ff <= geometry_in;
      end
   end

   assign geometry = geometry_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lxy_map_logic.sv =====
// walk of the openings that turns a strip index into a grid point
`default_nettype none

module lxy_map_logic
   import lxy_pkg::*;
(
   input  wire logic        [15:0] led_index,
   input  wire logic               compressed_mode,
   input  wire geometry_array_type geometry,
   output      result_type         result
);

   always_comb begin
      logic [15:0] pos;
      logic [15:0] packed_x;
      logic [15:0] left16;
      logic [15:0] top16;
      logic [15:0] right16;
      logic [15:0] total;
      logic [15:0] base_x;
      logic [15:0] run_pos;
      logic        found;

      pos             = led_index;
      packed_x        = '0;
      found           = 1'b0;
      result.coord_x  = COORD_NONE;
      result.coord_y  = COORD_NONE;
      result.in_range = 1'b0;

      for (int k = 0; k < MAPPED_OPENINGS; k++) begin
         left16  = {8'h00, geometry[k].left_count};
         top16   = {8'h00, geometry[k].top_count};
         right16 = {8'h00, geometry[k].right_count};
         total   = left16 + top16 + right16;
         base_x  = compressed_mode ? packed_x : geometry[k].x_offset;
         run_pos = pos - left16 - top16;
         if (!found) begin
            if (pos < total) begin
               found           = 1'b1;
               result.in_range = 1'b1;
               if (pos < left16) begin
                  result.coord_x = base_x;
                  result.coord_y = geometry[k].y_offset + pos;
               end else if (pos < (left16 + top16)) begin
                  result.coord_x = base_x + (pos - left16);
                  result.coord_y = geometry[k].y_offset + left16;
               end else begin
                  result.coord_x = base_x + top16;
                  result.coord_y = geometry[k].y_offset + left16 - run_pos;
               end
            end else begin
               pos      = pos - total;
               packed_x = packed_x + top16;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/led_index_to_xy_mapper.sv =====
// top level of the led index to xy mapper
//
//   channel | direction | tdata                          | tuser
//   req     | in        | led_index[15:0]                | compressed_mode[0]
//   rsp     | out       | coord_x[15:0], coord_y[31:16]  | in_range[0]
//   csr     | in        | csr_data: opening geometry     | csr_index: register
//
// one index per clock while rsp_tready is high; input register then result register
// the opening walk is one combinational pass between the two registers
// synchronous reset clears the pipeline valids and the geometry registers
// a stalled result holds while one more index waits in the input register
`default_nettype none

module led_index_to_xy_mapper
   import lxy_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [15:0]                req_tdata,   // led_index[15:0]
   input  wire logic [0:0]                 req_tuser,   // compressed_mode[0]
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [31:0]                rsp_tdata,   // coord_x[15:0], coord_y[31:16]
   output      logic [0:0]                 rsp_tuser,   // in_range[0]
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [GEOMETRY_WIDTH-1:0]  csr_data
);

`include "led_index_to_xy_mapper_assert.svh"

   geometry_array_type geometry;
   result_type         map_result;

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_index_ff, s1_index_in;
   logic        s1_mode_ff,  s1_mode_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_result_ff, rsp_result_in;

   logic req_transfer;
   logic rsp_load;

   assign csr_ready = !reset;

   lxy_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geometry  (geometry)
   );

   lxy_map_logic u_map_logic (
      .led_index       (s1_index_ff),
      .compressed_mode (s1_mode_ff),
      .geometry        (geometry),
      .result          (map_result)
   );

   assign rsp_load     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !reset && (!s1_valid_ff || rsp_load);
   assign req_transfer = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_index_in   = s1_index_ff;
      s1_mode_in    = s1_mode_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (rsp_load) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_result_in = map_result;
         s1_valid_in   = 1'b0;
      end
      if (req_transfer) begin
         s1_valid_in = 1'b1;
         s1_index_in = req_tdata;
         s1_mode_in  = req_tuser[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff   <= s1_index_in;
      s1_mode_ff    <= s1_mode_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_result_ff.coord_y, rsp_result_ff.coord_x};
   assign rsp_tuser[0] = rsp_result_ff.in_range;

   // out of range results carry minus one in both coordinates
   `LXY_ASSERT(a_out_of_range_coords, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'hFFFF_FFFF, "out of range result without minus one coordinates")

   // an accepted index always lands in the input register
   `LXY_ASSERT(a_req_captured, clock, reset, req_tvalid && req_tready |=> s1_valid_ff, "accepted index not captured")

   // a held index moves to the result register when it is free
   `LXY_ASSERT(a_s1_advances, clock, reset, s1_valid_ff && rsp_load |=> rsp_tvalid, "input register did not advance")

   // no new index is taken while both registers are full and stalled
   `LXY_ASSERT(a_no_overrun, clock, reset, s1_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready, "index accepted while pipeline full")

endmodule

`default_nettype wire
